[rtl/dip_window_zero_mask_defines.svh]
// Assertion macros for the checker of the zero mask block.
`ifndef DIP_WINDOW_ZERO_MASK_DEFINES_SVH
`define DIP_WINDOW_ZERO_MASK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DWZM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DWZM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dwzm_pkg.sv]
// Package with sizes, codes and shared types of the zero mask block.
`timescale 1ns / 1ps
package dwzm_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HALF_WIDTH = 8;
    localparam int MAX_STRETCH    = 4;

    localparam int MAX_REACH  = MAX_HALF_WIDTH * MAX_STRETCH;
    localparam int LINE_DEPTH = MAX_WIDTH + 2 * MAX_REACH + 1;
    localparam int LINE_IDX_W = $clog2(LINE_DEPTH);
    localparam int DIFF_W     = LINE_IDX_W + 1;

    localparam int HW_W     = 4;
    localparam int STR_W    = 3;
    localparam int LW_W     = 11;
    localparam int SAMPLE_W = 32;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int REACH_W = $clog2(MAX_REACH + 1);
    localparam int SPAN_W  = $clog2(2 * MAX_REACH + 1);
    localparam int PEND_W  = $clog2(MAX_WIDTH + MAX_REACH + 1);
    localparam int PROD_W  = HW_W + STR_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LW_W;

    localparam int TREE_GROUP  = 33;
    localparam int TREE_GROUPS = (LINE_DEPTH + TREE_GROUP - 1) / TREE_GROUP;
    localparam int TREE_PAD_W  = TREE_GROUPS * TREE_GROUP;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd2;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    localparam logic [HW_W-1:0]  HALF_WIDTH_RST = 4'd1;
    localparam logic [STR_W-1:0] STRETCH_RST    = 3'd1;
    localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 11'd1024;

    // Tap geometry that every cell of the flag line needs.
    typedef struct packed {
        logic [LW_W-1:0]   width;
        logic [SPAN_W-1:0] span;
        logic [STR_W-1:0]  stretch;
    } tap_cfg_t;

    // Side information that travels with a result word down the pipeline.
    typedef struct packed {
        logic flush;
        logic last;
        logic in_range;
    } res_ctl_t;

endpackage

[rtl/dwzm_if.sv]
// Stream interfaces for the sample words and the mask words.
`timescale 1ns / 1ps
interface dwzm_sample_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [dwzm_pkg::SAMPLE_W-1:0] sample_bits;

    modport source (output valid, output command, output sample_bits, input ready);
    modport sink (input valid, input command, input sample_bits, output ready);
endinterface

interface dwzm_mask_if;
    logic valid;
    logic ready;
    logic mask_bit;
    logic last;

    modport source (output valid, output mask_bit, output last, input ready);
    modport sink (input valid, input mask_bit, input last, output ready);
endinterface

[rtl/dip_window_zero_mask.sv]
// Top level of the streaming zero mask: counters, flag line, OR tree and output register.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-------------------------------------
//  samples   | in  | valid / ready | command (1), sample_bits (32)
//  masks     | out | valid / ready | mask_bit (1), last (1)
//  cfg       | in  | cfg_we        | cfg_index (2), cfg_data (11)
//
// One word is taken every cycle while samples.ready is high; a word that yields a mask bit
// passes stage 1, the tree capture stage and the output register before it shows.
// Reset clears the configuration to its defaults, the counters and the whole flag line.
// samples.ready falls only while the output register holds a word that masks does
// not take and the two stages behind it are full; bubbles are squeezed out first.
`timescale 1ns / 1ps
module dip_window_zero_mask (
    input  logic                          clk,
    input  logic                          rst_n,
    dwzm_sample_if.sink                   samples,
    dwzm_mask_if.source                   masks,
    input  logic                          cfg_we,
    input  logic [dwzm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dwzm_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers, as written.
    logic [dwzm_pkg::HW_W-1:0]  half_width_reg;
    logic [dwzm_pkg::HW_W-1:0]  half_width_next;
    logic [dwzm_pkg::STR_W-1:0] stretch_reg;
    logic [dwzm_pkg::STR_W-1:0] stretch_next;
    logic [dwzm_pkg::LW_W-1:0]  line_width_reg;
    logic [dwzm_pkg::LW_W-1:0]  line_width_next;

    // Values in force after clamping to the supported ranges.
    logic [dwzm_pkg::LW_W-1:0]    eff_width;
    logic [dwzm_pkg::STR_W-1:0]   eff_stretch;
    logic [dwzm_pkg::HW_W-1:0]    eff_half;
    logic [dwzm_pkg::PROD_W-1:0]  reach_prod;
    logic [dwzm_pkg::REACH_W-1:0] reach;
    logic [dwzm_pkg::SPAN_W-1:0]  span;
    logic [dwzm_pkg::LW_W-1:0]    delay;
    dwzm_pkg::tap_cfg_t           tap_cfg;

    // Image counters.
    logic [dwzm_pkg::COL_W-1:0]  col_reg;
    logic [dwzm_pkg::COL_W-1:0]  col_next;
    logic [dwzm_pkg::COL_W-1:0]  col_eff;
    logic [dwzm_pkg::LW_W-1:0]   col_inc;
    logic [dwzm_pkg::PEND_W-1:0] pend_reg;
    logic [dwzm_pkg::PEND_W-1:0] pend_next;

    logic               accept;
    logic               is_flush;
    logic               line_shift;
    logic               res_valid;
    dwzm_pkg::res_ctl_t res_ctl;

    // Pipeline: stage 1 marks the line state to evaluate, stage 2 holds the first
    // tree level, the output register holds the finished word.
    logic               v1_reg;
    logic               v2_reg;
    logic               out_valid_reg;
    dwzm_pkg::res_ctl_t ctl1_reg;
    dwzm_pkg::res_ctl_t ctl2_reg;
    logic               out_mask_reg;
    logic               out_last_reg;
    logic               adv1;
    logic               adv2;
    logic               adv3;
    logic               tree_any;

    // Flag line wiring.
    logic [dwzm_pkg::LINE_DEPTH-1:0] chain;
    logic [dwzm_pkg::LINE_DEPTH-1:0] hits;

    // ------------------------------------------------------------------
    // Configuration port. Writes beyond the register list are dropped.
    // ------------------------------------------------------------------
    always_comb
    begin
        half_width_next = half_width_reg;
        stretch_next    = stretch_reg;
        line_width_next = line_width_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dwzm_pkg::CFG_HALF_WIDTH: half_width_next = cfg_data[dwzm_pkg::HW_W-1:0];
                dwzm_pkg::CFG_STRETCH:    stretch_next    = cfg_data[dwzm_pkg::STR_W-1:0];
                dwzm_pkg::CFG_LINE_WIDTH: line_width_next = cfg_data[dwzm_pkg::LW_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= dwzm_pkg::HALF_WIDTH_RST;
            stretch_reg    <= dwzm_pkg::STRETCH_RST;
            line_width_reg <= dwzm_pkg::LINE_WIDTH_RST;
        end
        else
        begin
            half_width_reg <= half_width_next;
            stretch_reg    <= stretch_next;
            line_width_reg <= line_width_next;
        end
    end

    // Out-of-range settings act as the nearest supported value.
    always_comb
    begin
        if (line_width_reg == '0)
            eff_width = dwzm_pkg::LW_W'(1);
        else if (line_width_reg > dwzm_pkg::LW_W'(dwzm_pkg::MAX_WIDTH))
            eff_width = dwzm_pkg::LW_W'(dwzm_pkg::MAX_WIDTH);
        else
            eff_width = line_width_reg;

        if (stretch_reg == '0)
            eff_stretch = dwzm_pkg::STR_W'(1);
        else if (stretch_reg > dwzm_pkg::STR_W'(dwzm_pkg::MAX_STRETCH))
            eff_stretch = dwzm_pkg::STR_W'(dwzm_pkg::MAX_STRETCH);
        else
            eff_stretch = stretch_reg;

        if (half_width_reg > dwzm_pkg::HW_W'(dwzm_pkg::MAX_HALF_WIDTH))
            eff_half = dwzm_pkg::HW_W'(dwzm_pkg::MAX_HALF_WIDTH);
        else
            eff_half = half_width_reg;
    end

    assign reach_prod = dwzm_pkg::PROD_W'(eff_half) * dwzm_pkg::PROD_W'(eff_stretch);
    assign reach      = dwzm_pkg::REACH_W'(reach_prod);
    assign span       = dwzm_pkg::SPAN_W'({reach, 1'b0});
    assign delay      = eff_width + dwzm_pkg::LW_W'(reach);

    assign tap_cfg.width   = eff_width;
    assign tap_cfg.span    = span;
    assign tap_cfg.stretch = eff_stretch;

    // ------------------------------------------------------------------
    // Counters and the decision whether an accepted word yields a result.
    // ------------------------------------------------------------------
    assign accept     = samples.valid & samples.ready;
    assign is_flush   = (samples.command == dwzm_pkg::CMD_FLUSH);
    assign line_shift = accept & ~is_flush;

    // A column left beyond a narrowed line restarts at zero.
    assign col_eff = (dwzm_pkg::LW_W'(col_reg) >= eff_width) ? '0 : col_reg;
    assign col_inc = dwzm_pkg::LW_W'(col_eff) + dwzm_pkg::LW_W'(1);

    always_comb
    begin
        pend_next        = pend_reg;
        col_next         = col_reg;
        res_valid        = 1'b0;
        res_ctl.flush    = 1'b0;
        res_ctl.last     = 1'b0;
        res_ctl.in_range = 1'b0;
        if (accept)
        begin
            col_next = col_eff;
            if (is_flush)
            begin
                // Each flush drains one owed bit as 0; the last one restarts the image.
                if (pend_reg == '0)
                begin
                    col_next = '0;
                end
                else
                begin
                    res_valid     = 1'b1;
                    res_ctl.flush = 1'b1;
                    res_ctl.last  = (pend_reg == dwzm_pkg::PEND_W'(1));
                    pend_next     = pend_reg - dwzm_pkg::PEND_W'(1);
                    if (pend_reg == dwzm_pkg::PEND_W'(1))
                    begin
                        col_next = '0;
                    end
                end
            end
            else if (dwzm_pkg::LW_W'(pend_reg) < delay)
            begin
                // Still filling: one row plus the reach must be in before the first bit.
                pend_next = pend_reg + dwzm_pkg::PEND_W'(1);
            end
            else
            begin
                res_valid        = 1'b1;
                res_ctl.in_range = (dwzm_pkg::LW_W'(col_eff) >= dwzm_pkg::LW_W'(reach))
                                   && (dwzm_pkg::LW_W'(col_eff) + dwzm_pkg::LW_W'(reach)
                                       < eff_width);
                col_next         = (col_inc >= eff_width) ? '0 : dwzm_pkg::COL_W'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            col_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            col_reg  <= col_next;
        end
    end

    // ------------------------------------------------------------------
    // Flag line: a row of cells; cell 0 takes the newest zero flag and every
    // accepted sample moves all flags one cell further down the line.
    // ------------------------------------------------------------------
    assign chain[0] = (samples.sample_bits[dwzm_pkg::SAMPLE_W-2:0] == '0);

    for (genvar i = 0; i < dwzm_pkg::LINE_DEPTH; i++) begin : g_cell
        if (i < dwzm_pkg::LINE_DEPTH - 1) begin : g_link
            dwzm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (line_shift),
                .flag_in  (chain[i]),
                .cfg      (tap_cfg),
                .index    (dwzm_pkg::LINE_IDX_W'(i)),
                .flag_out (chain[i+1]),
                .hit      (hits[i])
            );
        end
        else begin : g_tail
            dwzm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (line_shift),
                .flag_in  (chain[i]),
                .cfg      (tap_cfg),
                .index    (dwzm_pkg::LINE_IDX_W'(i)),
                .flag_out (),
                .hit      (hits[i])
            );
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance. Each stage moves when the one after it is empty or moving,
    // so a bubble anywhere lets a new sample in even while the output waits.
    // ------------------------------------------------------------------
    assign adv3 = ~out_valid_reg | masks.ready;
    assign adv2 = ~v2_reg | adv3;
    assign adv1 = ~v1_reg | adv2;

    assign samples.ready = adv1;

    // The tree samples the line while stage 1 holds the word the line state belongs to;
    // the line cannot shift again before that because stage 1 blocks new words.
    dwzm_or_tree u_or_tree (
        .clk     (clk),
        .capture (adv2),
        .hits    (hits),
        .any     (tree_any)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= res_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            ctl1_reg <= res_ctl;
        end
        if (adv2)
        begin
            ctl2_reg <= ctl1_reg;
        end
        if (adv3)
        begin
            // Drained bits are always 0; a pixel outside the valid columns is 0 too.
            out_mask_reg <= ~ctl2_reg.flush & ctl2_reg.in_range & tree_any;
            out_last_reg <= ctl2_reg.last;
        end
    end

    assign masks.valid    = out_valid_reg;
    assign masks.mask_bit = out_mask_reg;
    assign masks.last     = out_last_reg;

endmodule

[rtl/dwzm_cell.sv]
// One cell of the zero flag line: a flag bit, its neighbor link and its tap select.
`timescale 1ns / 1ps
module dwzm_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift,
    input  logic                          flag_in,
    input  dwzm_pkg::tap_cfg_t            cfg,
    input  logic [dwzm_pkg::LINE_IDX_W-1:0] index,
    output logic                          flag_out,
    output logic                          hit
);

    // True when offset d is a whole multiple of the tap spacing s.
    function automatic logic spacing_ok(
        input logic [dwzm_pkg::SPAN_W-1:0]  d,
        input logic [dwzm_pkg::STR_W-1:0]   s
    );
        logic [dwzm_pkg::SPAN_W:0] dx;
        logic [3:0]                sum;
        logic [2:0]                sum2;
        logic                      ok;
        dx  = {1'b0, d};
        sum = '0;
        // Base-4 digits sum to the value modulo 3.
        for (int k = 0; k < (dwzm_pkg::SPAN_W + 1) / 2; k++) begin
            sum = sum + 4'(dx[2*k +: 2]);
        end
        sum2 = 3'(sum[1:0]) + 3'(sum[3:2]);
        unique case (s)
            3'd2:    ok = ~d[0];
            3'd3:    ok = (sum2 == 3'd0) || (sum2 == 3'd3) || (sum2 == 3'd6);
            3'd4:    ok = (d[1:0] == 2'd0);
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    logic                          flag_reg;
    logic                          flag_next;
    logic                          sel_reg;
    logic                          sel_next;
    logic [dwzm_pkg::DIFF_W-1:0]   diff;
    logic                          near_tap;
    logic                          far_tap;

    assign diff = dwzm_pkg::DIFF_W'(index) - dwzm_pkg::DIFF_W'(cfg.width);

    // A cell is a tap of the newer row window or of the row one line back.
    assign near_tap = (index <= dwzm_pkg::LINE_IDX_W'(cfg.span))
                      && spacing_ok(index[dwzm_pkg::SPAN_W-1:0], cfg.stretch);
    assign far_tap  = ~diff[dwzm_pkg::DIFF_W-1]
                      && (diff[dwzm_pkg::DIFF_W-2:0] <= dwzm_pkg::LINE_IDX_W'(cfg.span))
                      && spacing_ok(diff[dwzm_pkg::SPAN_W-1:0], cfg.stretch);

    assign sel_next  = near_tap | far_tap;
    assign flag_next = shift ? flag_in : flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
            sel_reg  <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
            sel_reg  <= sel_next;
        end
    end

    assign flag_out = flag_reg;
    assign hit      = flag_reg & sel_reg;

endmodule

[rtl/dwzm_or_tree.sv]
// Two-level registered OR tree over the tap hits of the flag line.
`timescale 1ns / 1ps
module dwzm_or_tree (
    input  logic                          clk,
    input  logic                          capture,
    input  logic [dwzm_pkg::LINE_DEPTH-1:0] hits,
    output logic                          any
);

    logic [dwzm_pkg::TREE_PAD_W-1:0]  padded;
    logic [dwzm_pkg::TREE_GROUPS-1:0] level_reg;
    logic [dwzm_pkg::TREE_GROUPS-1:0] level_next;

    assign padded = dwzm_pkg::TREE_PAD_W'(hits);

    always_comb
    begin
        for (int g = 0; g < dwzm_pkg::TREE_GROUPS; g++) begin
            level_next[g] = |padded[g*dwzm_pkg::TREE_GROUP +: dwzm_pkg::TREE_GROUP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            level_reg <= level_next;
        end
    end

    assign any = |level_reg;

endmodule

[rtl/dwzm_checker.sv]
// Port checker for the zero mask block and its bind to the top level.
`timescale 1ns / 1ps
`include "dip_window_zero_mask_defines.svh"
module dwzm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic mask_bit,
    input logic last
);

    // A word that is not taken stays offered.
    `DWZM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "mask word dropped while stalled")

    // Its payload does not change while it waits.
    `DWZM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(mask_bit) && $stable(last), "mask payload changed while stalled")

    // With the output side taking words the block never stalls its input.
    `DWZM_ASSERT_IMPL(a_no_stall, clk, rst_n, out_ready, in_ready, "input stalled while output drains")

    // The closing word of an image is a drained bit and therefore 0.
    `DWZM_ASSERT_IMPL(a_last_zero, clk, rst_n, out_valid && last, !mask_bit, "last word carries a set mask bit")

endmodule

bind dip_window_zero_mask dwzm_checker u_dwzm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (masks.valid),
    .out_ready (masks.ready),
    .mask_bit  (masks.mask_bit),
    .last      (masks.last)
);
